@@ hw/rtl/csvft_pkg.sv @@
// Shared types and constants of the CSV field tokenizer.
package csvft_pkg;

	// Reset values of the configuration registers.
	localparam logic [7:0] SEP_RESET     = 8'd44;
	localparam logic [7:0] QUOTE_RESET   = 8'd34;
	localparam logic [7:0] COMMENT_RESET = 8'd37;

	// Newline ends a row.
	localparam logic [7:0] NEWLINE_BYTE = 8'd10;

	// Configuration register indexes.
	localparam logic [1:0] REG_SEP     = 2'd0;
	localparam logic [1:0] REG_QUOTE   = 2'd1;
	localparam logic [1:0] REG_COMMENT = 2'd2;

	// Input actions.
	localparam logic ACT_BYTE = 1'b0;
	localparam logic ACT_END  = 1'b1;

	// Result kinds.
	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_EOF  = 2'd1;
	localparam logic [1:0] KIND_EOR  = 2'd2;

	// Parse modes.
	localparam logic [2:0] M_LINE   = 3'd0;
	localparam logic [2:0] M_FSTART = 3'd1;
	localparam logic [2:0] M_UNQ    = 3'd2;
	localparam logic [2:0] M_QUO    = 3'd3;
	localparam logic [2:0] M_QSEEN  = 3'd4;
	localparam logic [2:0] M_COMM   = 3'd5;

	// Result queue depth; a power of two, at least two.
	localparam int RQ_DEPTH = 4;

	typedef struct packed {
		logic       action;
		logic [7:0] in_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] out_byte;
		logic       last;
	} out_item_t;

endpackage

@@ hw/rtl/csv_field_tokenizer.sv @@
// Top level of the CSV field tokenizer: input register, parser and result queue.
//
// The tokenizer takes one text byte (or an end-of-input mark) per cycle while the
// result queue has room, and emits field bytes, end-of-field and end-of-row
// markers, at most two per input item, the last one flagged with last. An accepted
// item sits in one input register and its results enter a four-entry result queue
// at the clock edge on which it leaves that register, which waits for room in the
// queue; results are offered from the queue head. Input is taken every cycle while
// the queue has room for two results; the result side delivers one result per cycle
// while result_ready is high, so items that cause two results drain slower than they
// arrive and the queue depth sets how long input keeps flowing in that case.
// Configuration writes take effect at once and are meant for idle periods.
module csv_field_tokenizer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  csvft_pkg::in_item_t  item,
	output logic                 result_valid,
	input  logic                 result_ready,
	output csvft_pkg::out_item_t result,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [7:0]           cfg_data
);
	import csvft_pkg::*;

	localparam int PTR_W = $clog2(RQ_DEPTH);
	localparam int CNT_W = $clog2(RQ_DEPTH + 1);
	localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(RQ_DEPTH - 2);
	localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(RQ_DEPTH);

	logic [7:0] sep_q;
	logic [7:0] quote_q;
	logic [7:0] comment_q;
	logic [2:0] mode_q;
	logic [2:0] mode_nx;

	logic     valid_s1;
	in_item_t item_s1;
	logic     adv_s1;

	out_item_t             rq_q [RQ_DEPTH];
	logic [PTR_W-1:0]      wr_ptr_q;
	logic [PTR_W-1:0]      rd_ptr_q;
	logic [PTR_W-1:0]      wr_ptr_nx1;
	logic [CNT_W-1:0]      count_q;
	logic                  pop;

	out_item_t  res0;
	out_item_t  res1;
	logic [1:0] n_res;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_q     <= SEP_RESET;
			quote_q   <= QUOTE_RESET;
			comment_q <= COMMENT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SEP:     sep_q     <= cfg_data;
				REG_QUOTE:   quote_q   <= cfg_data;
				REG_COMMENT: comment_q <= cfg_data;
				default:     ;
			endcase
		end
	end

	// The input register moves on when the queue can hold two more results.
	assign adv_s1     = valid_s1 && (count_q <= ROOM_LIMIT);
	assign item_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	// Parser: results and next mode for the item in the input register.
	always_comb begin
		logic [7:0] b;
		logic       in_field;
		b        = item_s1.in_byte;
		in_field = (mode_q == M_UNQ) || (mode_q == M_QUO) || (mode_q == M_QSEEN);
		res0     = '{kind: KIND_EOF, out_byte: 8'd0, last: 1'b0};
		res1     = '{kind: KIND_EOR, out_byte: 8'd0, last: 1'b1};
		n_res    = 2'd0;
		mode_nx  = mode_q;
		if (item_s1.action == ACT_END || b == NEWLINE_BYTE) begin
			// Row end: close an open field, then the row.
			mode_nx = M_LINE;
			if (in_field) begin
				n_res = 2'd2;
			end else if (item_s1.action == ACT_BYTE || mode_q != M_LINE) begin
				n_res = 2'd1;
				res0  = '{kind: KIND_EOR, out_byte: 8'd0, last: 1'b1};
			end
			if (mode_q > M_COMM && item_s1.action == ACT_END) begin
				// Unused codes act as line start.
				n_res = 2'd0;
			end
		end else begin
			unique case (mode_q)
				M_UNQ: begin
					n_res = 2'd1;
					if (b == sep_q) begin
						res0    = '{kind: KIND_EOF, out_byte: 8'd0, last: 1'b1};
						mode_nx = M_FSTART;
					end else begin
						res0 = '{kind: KIND_BYTE, out_byte: b, last: 1'b1};
					end
				end
				M_QUO: begin
					if (b == quote_q) begin
						mode_nx = M_QSEEN;
					end else begin
						n_res = 2'd1;
						res0  = '{kind: KIND_BYTE, out_byte: b, last: 1'b1};
					end
				end
				M_QSEEN: begin
					if (b == quote_q) begin
						// Doubled quote stands for one literal quote.
						n_res   = 2'd1;
						res0    = '{kind: KIND_BYTE, out_byte: b, last: 1'b1};
						mode_nx = M_QUO;
					end else if (b == sep_q) begin
						n_res   = 2'd1;
						res0    = '{kind: KIND_EOF, out_byte: 8'd0, last: 1'b1};
						mode_nx = M_FSTART;
					end else begin
						// A stray byte closes the field and opens a new one.
						n_res   = 2'd2;
						res1    = '{kind: KIND_BYTE, out_byte: b, last: 1'b1};
						mode_nx = M_UNQ;
					end
				end
				M_COMM: begin
					mode_nx = M_COMM;
				end
				default: begin
					// Line start, field start and unused codes.
					if (mode_q != M_FSTART && b == comment_q) begin
						mode_nx = M_COMM;
					end else if (b == quote_q) begin
						mode_nx = M_QUO;
					end else if (b == sep_q) begin
						n_res   = 2'd1;
						res0    = '{kind: KIND_EOF, out_byte: 8'd0, last: 1'b1};
						mode_nx = M_FSTART;
					end else begin
						n_res   = 2'd1;
						res0    = '{kind: KIND_BYTE, out_byte: b, last: 1'b1};
						mode_nx = M_UNQ;
					end
				end
			endcase
		end
	end

	// Parse mode advances with each item that leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_LINE;
		end else if (adv_s1) begin
			mode_q <= mode_nx;
		end
	end

	// Result queue: up to two writes per cycle, one read at the head.
	assign pop          = result_valid && result_ready;
	assign result_valid = (count_q != '0);
	assign result       = rq_q[rd_ptr_q];
	assign wr_ptr_nx1   = wr_ptr_q + PTR_W'(1);

	always_ff @(posedge clk) begin
		if (adv_s1 && n_res != 2'd0) begin
			rq_q[wr_ptr_q] <= res0;
		end
		if (adv_s1 && n_res == 2'd2) begin
			rq_q[wr_ptr_nx1] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (adv_s1) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(n_res);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + (adv_s1 ? CNT_W'(n_res) : '0) - CNT_W'(pop);
		end
	end

	// The queue never overfills.
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= FULL_COUNT)
		else $error("result queue overflow");

	// End of input always returns the parser to line start.
	assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && item_s1.action == ACT_END |=> mode_q == M_LINE)
		else $error("end of input left a pending mode");

	// Markers carry a zero byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind != KIND_BYTE |-> result.out_byte == 8'd0)
		else $error("marker with nonzero byte");

	// Only defined result kinds leave the block.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.kind != 2'd3)
		else $error("undefined result kind");

	// A pair of results has exactly one last flag, on the second.
	assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && n_res == 2'd2 |-> !res0.last && res1.last)
		else $error("bad last flag on a result pair");

endmodule
